/* design/bfmm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package bfmm_pkg;

  localparam int MaxK = 128;
  localparam int MaxN = 64;
  localparam int StoreDepth = MaxK * MaxN;
  localparam int AddrW = $clog2(StoreDepth);
  localparam int KW = $clog2(MaxK + 1);
  localparam int NW = $clog2(MaxN + 1);
  localparam int JW = (MaxN > 1) ? $clog2(MaxN) : 1;
  localparam int KPosW = (MaxK > 1) ? $clog2(MaxK) : 1;

  localparam logic [31:0] CanonNan = 32'h7FC00000;
  localparam logic [31:0] PosInf = 32'h7F800000;

  // Configuration register indexes.
  localparam logic [1:0] RegRowsM = 2'd0;
  localparam logic [1:0] RegDepthK = 2'd1;
  localparam logic [1:0] RegColsN = 2'd2;
  localparam logic [1:0] RegBatchCount = 2'd3;

  typedef enum logic [2:0] {
    StLoadB,
    StIdleA,
    StMac,
    StMacWait,
    StEmit
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             b_write;
    logic [AddrW-1:0] b_addr;
    logic             a_capture;
    logic             mac_issue;
    logic             first_k;
    logic [JW-1:0]    col;
    logic             emit_read;
  } dp_cmd_t;

  // Status from the datapath.
  typedef struct packed {
    logic mac_done;
    logic emit_valid;
  } dp_stat_t;

  // Position of the leading one in a 48-bit value (0 when zero).
  function automatic logic [5:0] lead48(input logic [47:0] v);
    logic [5:0] p;
    p = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction

endpackage
`default_nettype wire

/* design/bfmm_stream_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface bfmm_stream_if #(
  parameter int Width = 32
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bfmm_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] result;
  logic [15:0] row;
  logic [5:0]  col;
  logic        last_of_row;
  logic        last_of_batch;
  logic        last_of_job;

  modport source (output valid, output result, output row, output col,
                  output last_of_row, output last_of_batch, output last_of_job,
                  input ready);
  modport sink (input valid, input result, input row, input col,
                input last_of_row, input last_of_batch, input last_of_job,
                output ready);
endinterface
`default_nettype wire

/* design/bfmm_fma.sv */
`timescale 1ns / 1ps
`default_nettype none
// Multi-cycle binary32 fused multiply-add, round to nearest even.
// Stages: unpack+multiply, align, add, normalize, round.
module bfmm_fma
  import bfmm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  input  wire logic [31:0] c_i,
  output logic             done_o,
  output logic [31:0]      z_o
);

  typedef enum logic [2:0] {
    FIdle, FAlign, FAdd, FNorm, FRound
  } fma_state_e;

  fma_state_e st_q, st_d;

  // Payload registers.
  logic        special_q;
  logic [31:0] special_val_q;
  logic        sp_q, sc_q, c_zero_q;
  logic [47:0] mp_q;
  logic signed [10:0] ep_q;
  logic [23:0] mc_q;
  logic signed [10:0] ec_q;
  logic [63:0] big_q, small_q;
  logic signed [10:0] ebig_q;
  logic        sbig_q;
  logic        sub_q;
  logic [63:0] sum_q;
  logic [5:0]  top_q;

  // Unpack stage logic.
  logic        sp, sc;
  logic [30:0] am, bm, cm;
  logic [23:0] ma, mb, mc;
  logic signed [10:0] ea, eb, ec;
  logic        spec;
  logic [31:0] spec_val;

  always_comb begin
    sp = a_i[31] ^ b_i[31];
    sc = c_i[31];
    am = a_i[30:0];
    bm = b_i[30:0];
    cm = c_i[30:0];
    ma = (a_i[30:23] == 8'd0) ? {1'b0, a_i[22:0]} : {1'b1, a_i[22:0]};
    mb = (b_i[30:23] == 8'd0) ? {1'b0, b_i[22:0]} : {1'b1, b_i[22:0]};
    mc = (c_i[30:23] == 8'd0) ? {1'b0, c_i[22:0]} : {1'b1, c_i[22:0]};
    ea = (a_i[30:23] == 8'd0) ? -11'sd149 : $signed({3'b000, a_i[30:23]}) - 11'sd150;
    eb = (b_i[30:23] == 8'd0) ? -11'sd149 : $signed({3'b000, b_i[30:23]}) - 11'sd150;
    ec = (c_i[30:23] == 8'd0) ? -11'sd149 : $signed({3'b000, c_i[30:23]}) - 11'sd150;
    spec = 1'b1;
    spec_val = 32'd0;
    if (am > PosInf[30:0] || bm > PosInf[30:0] || cm > PosInf[30:0]) begin
      spec_val = CanonNan;
    end else if (am == PosInf[30:0] || bm == PosInf[30:0]) begin
      if (am == 31'd0 || bm == 31'd0) spec_val = CanonNan;
      else if (cm == PosInf[30:0] && sc != sp) spec_val = CanonNan;
      else spec_val = {sp, PosInf[30:0]};
    end else if (cm == PosInf[30:0]) begin
      spec_val = c_i;
    end else if (am == 31'd0 || bm == 31'd0) begin
      if (cm == 31'd0) spec_val = (sc == sp) ? c_i : 32'd0;
      else spec_val = c_i;
    end else begin
      spec = 1'b0;
    end
  end

  // Align stage: normalize both to bit 61 and order by magnitude.
  logic [5:0]  tp, tc;
  logic [63:0] np, nc;
  logic signed [10:0] nep, nec, dd;
  logic        p_big;
  logic [63:0] bg, sm, sm_sh;
  logic [6:0]  dsh;

  always_comb begin
    tp = lead48(mp_q);
    tc = lead48({24'd0, mc_q});
    np = {16'd0, mp_q} << (7'd61 - {1'b0, tp});
    nc = {40'd0, mc_q} << (7'd61 - {1'b0, tc});
    nep = ep_q - $signed({5'd0, 6'd61 - tp});
    nec = ec_q - $signed({5'd0, 6'd61 - tc});
    p_big = (nep > nec) || (nep == nec && np >= nc);
    bg = p_big ? np : nc;
    sm = p_big ? nc : np;
    dd = p_big ? (nep - nec) : (nec - nep);
    dsh = (dd >= 11'sd63) ? 7'd63 : dd[6:0];
    if (dd >= 11'sd63) sm_sh = 64'd1;
    else begin
      sm_sh = sm >> dsh;
      if ((sm & ((64'd1 << dsh) - 64'd1)) != 64'd0) sm_sh[0] = 1'b1;
    end
  end

  // Add stage.
  logic [63:0] sum;
  always_comb sum = sub_q ? (big_q - small_q) : (big_q + small_q);

  // Round stage: sbig * sum_q * 2^ebig, top bit at top_q.
  logic signed [11:0] biased, sh;
  logic [63:0] q, rem, half, bits;
  logic [5:0]  shu;
  logic [31:0] rounded;

  always_comb begin
    biased = $signed({6'd0, top_q}) + 12'(ebig_q) + 12'sd127;
    if (biased >= 12'sd1) sh = $signed({6'd0, top_q}) - 12'sd23;
    else sh = -12'sd149 - 12'(ebig_q);
    shu = 6'd0;
    q = 64'd0;
    rem = 64'd0;
    half = 64'd0;
    if (sh <= 12'sd0) begin
      q = sum_q << 6'(-sh);
    end else if (sh >= 12'sd64) begin
      q = 64'd0;
    end else begin
      shu = sh[5:0];
      rem = sum_q & ((64'd1 << shu) - 64'd1);
      half = 64'd1 << (shu - 6'd1);
      q = sum_q >> shu;
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    end
    bits = ((biased >= 12'sd1) ? {{41{1'b0}}, 23'(biased - 12'sd1)} << 23 : 64'd0) + q;
    if (bits >= {32'd0, PosInf}) bits = {32'd0, PosInf};
    rounded = {sbig_q, bits[30:0]};
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      FIdle:  if (start_i) st_d = FAlign;
      FAlign: st_d = (special_q || c_zero_q) ? FNorm : FAdd;
      FAdd:   st_d = FNorm;
      FNorm:  st_d = FRound;
      FRound: st_d = FIdle;
      default: st_d = FIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= FIdle;
    else st_q <= st_d;
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      FIdle: if (start_i) begin
        special_q <= spec;
        special_val_q <= spec_val;
        sp_q <= sp;
        sc_q <= sc;
        c_zero_q <= (cm == 31'd0);
        mp_q <= ma * mb;
        ep_q <= ea + eb;
        mc_q <= mc;
        ec_q <= ec;
      end
      FAlign: begin
        if (c_zero_q) begin
          sum_q <= {16'd0, mp_q};
          ebig_q <= ep_q;
          sbig_q <= sp_q;
        end else begin
          big_q <= bg;
          small_q <= sm_sh;
          ebig_q <= p_big ? nep : nec;
          sbig_q <= p_big ? sp_q : sc_q;
          sub_q <= (sp_q != sc_q);
        end
      end
      FAdd: sum_q <= sum;
      FNorm: top_q <= lead48(sum_q[63:16]) + ((sum_q[63:16] != 48'd0) ? 6'd16 :
                      6'd0) + ((sum_q[63:16] == 48'd0) ? lead48(sum_q[47:0]) : 6'd0);
      default: ;
    endcase
  end

  assign done_o = (st_q == FRound);
  assign z_o = special_q ? special_val_q : ((sum_q == 64'd0) ? 32'd0 : rounded);

`ifndef SYNTH
  a_done_follows_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(st_q) == FNorm) else $error("fma done out of order");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == FAdd) |-> $past(st_q) == FAlign) else $error("fma add out of order");
  a_idle_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> st_q == FIdle) else $error("fma did not return to idle");
`endif

endmodule
`default_nettype wire

/* design/bfmm_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// B store, row accumulators and the shared FMA unit.
module bfmm_datapath
  import bfmm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire dp_cmd_t     cmd_i,
  input  wire logic [31:0] value_i,
  output dp_stat_t         stat_o,
  output logic [31:0]      acc_o
);

  logic [31:0] b_mem [StoreDepth];
  logic [31:0] acc_mem [MaxN];
  logic [31:0] b_rd_q, acc_rd_q, a_q, emit_q;
  logic        rd_pend_q, emit_pend_q;
  logic [JW-1:0] wcol_q;
  logic        first_q;
  logic        fma_done;
  logic [31:0] fma_z;

  // B store write and registered read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.b_write) b_mem[cmd_i.b_addr] <= value_i;
    b_rd_q <= b_mem[cmd_i.b_addr];
  end

  // Accumulator memory: FMA writeback, registered read.
  always_ff @(posedge clk_i) begin
    if (fma_done) acc_mem[wcol_q] <= fma_z;
    acc_rd_q <= acc_mem[cmd_i.col];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.a_capture) a_q <= value_i;
    if (cmd_i.mac_issue) begin
      wcol_q <= cmd_i.col;
      first_q <= cmd_i.first_k;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
      emit_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.mac_issue;
      emit_pend_q <= cmd_i.emit_read;
    end
  end

  bfmm_fma u_fma (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(rd_pend_q),
    .a_i    (a_q),
    .b_i    (b_rd_q),
    .c_i    (first_q ? 32'd0 : acc_rd_q),
    .done_o (fma_done),
    .z_o    (fma_z)
  );

  assign emit_q = acc_rd_q;
  assign acc_o = emit_q;
  assign stat_o.mac_done = fma_done;
  assign stat_o.emit_valid = emit_pend_q;

`ifndef SYNTH
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |=> !rd_pend_q) else $error("mac issued twice in a row");
  a_emit_not_during_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_pend_q |-> !rd_pend_q) else $error("emit read collides with mac");
  a_done_after_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fma_done |-> $past(rd_pend_q, 4) || $past(rd_pend_q, 3))
    else $error("fma finished without a start");
`endif

endmodule
`default_nettype wire

/* design/bfmm_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// Sequencer: B load, per-column MAC issue, row emission and position counters.
module bfmm_ctrl
  import bfmm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire dp_stat_t    stat_i,
  output dp_cmd_t          cmd_o,
  input  wire logic        out_ready_i,
  output logic             out_valid_o,
  output logic [15:0]      out_row_o,
  output logic [5:0]       out_col_o,
  output logic             out_lr_o,
  output logic             out_lb_o,
  output logic             out_lj_o
);

  ctrl_state_e st_q, st_d;
  logic [15:0] rows_q, batches_q;
  logic [7:0]  depth_q;
  logic [6:0]  cols_q;
  logic [15:0] eff_m, eff_b;
  logic [KW-1:0] eff_k;
  logic [NW-1:0] eff_n;
  logic [AddrW:0] b_total;
  logic [AddrW:0] bcnt_q, bcnt_d;
  logic [KPosW-1:0] kpos_q, kpos_d;
  logic [15:0] rowpos_q, rowpos_d, batchpos_q, batchpos_d, erow_q, erow_d;
  logic [JW-1:0] col_q, col_d;
  logic [AddrW-1:0] kbase_q, kbase_d;
  logic        lastb_q, lastb_d, lastj_q, lastj_d;
  logic        accept, last_col, out_busy_q, out_busy_d;

  // Effective sizes with zero and saturation rules.
  always_comb begin
    eff_m = (rows_q == 16'd0) ? 16'd1 : rows_q;
    eff_b = (batches_q == 16'd0) ? 16'd1 : batches_q;
    if (depth_q == 8'd0) eff_k = KW'(1);
    else if ({24'd0, depth_q} > 32'(MaxK)) eff_k = KW'(MaxK);
    else eff_k = KW'(depth_q);
    if (cols_q == 7'd0) eff_n = NW'(1);
    else if ({25'd0, cols_q} > 32'(MaxN)) eff_n = NW'(MaxN);
    else eff_n = NW'(cols_q);
    b_total = (AddrW + 1)'(eff_k) * (AddrW + 1)'(eff_n);
  end

  assign accept = in_valid_i && in_ready_o;
  assign last_col = ({1'b0, col_q} == NW'(eff_n - NW'(1)));

  // Next state.
  always_comb begin
    st_d = st_q;
    case (st_q)
      StLoadB: if (accept && (bcnt_q + 1'b1) >= b_total) st_d = StIdleA;
      StIdleA: if (accept) st_d = StMac;
      StMac:   st_d = StMacWait;
      StMacWait: if (stat_i.mac_done) begin
        if (!last_col) st_d = StMac;
        else if ({1'b0, kpos_q} + 1'b1 >= eff_k) st_d = StEmit;
        else st_d = StIdleA;
      end
      StEmit: if (stat_i.emit_valid && out_ready_i && last_col)
        st_d = lastb_q ? StLoadB : StIdleA;
      default: st_d = StLoadB;
    endcase
  end

  // Outputs and counters.
  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    bcnt_d = bcnt_q;
    kpos_d = kpos_q;
    rowpos_d = rowpos_q;
    batchpos_d = batchpos_q;
    erow_d = erow_q;
    col_d = col_q;
    kbase_d = kbase_q;
    lastb_d = lastb_q;
    lastj_d = lastj_q;
    out_busy_d = out_busy_q;
    cmd_o.col = col_q;
    cmd_o.b_addr = AddrW'(kbase_q + AddrW'(col_q));
    case (st_q)
      StLoadB: begin
        in_ready_o = 1'b1;
        cmd_o.b_addr = bcnt_q[AddrW-1:0];
        cmd_o.b_write = accept;
        if (accept) begin
          bcnt_d = bcnt_q + 1'b1;
          if (bcnt_d >= b_total) begin
            bcnt_d = '0;
            kpos_d = '0;
            kbase_d = '0;
          end
        end
      end
      StIdleA: begin
        in_ready_o = 1'b1;
        cmd_o.a_capture = accept;
        col_d = '0;
      end
      StMac: begin
        cmd_o.mac_issue = 1'b1;
        cmd_o.first_k = (kpos_q == '0);
      end
      StMacWait: if (stat_i.mac_done) begin
        if (!last_col) col_d = col_q + 1'b1;
        else begin
          col_d = '0;
          if ({1'b0, kpos_q} + 1'b1 >= eff_k) begin
            kpos_d = '0;
            kbase_d = '0;
            erow_d = rowpos_q;
            lastb_d = 1'b0;
            lastj_d = 1'b0;
            rowpos_d = rowpos_q + 16'd1;
            if (rowpos_d >= eff_m) begin
              rowpos_d = '0;
              lastb_d = 1'b1;
              batchpos_d = batchpos_q + 16'd1;
              if (batchpos_d >= eff_b) begin
                batchpos_d = '0;
                lastj_d = 1'b1;
              end
            end
          end else begin
            kpos_d = kpos_q + 1'b1;
            kbase_d = AddrW'(kbase_q + AddrW'(eff_n));
          end
        end
      end
      StEmit: begin
        // Read one accumulator; it shows on the output the next cycle and is
        // read again every cycle until the result item is taken.
        if (!out_busy_q) begin
          cmd_o.emit_read = 1'b1;
          out_busy_d = 1'b1;
        end else if (stat_i.emit_valid && out_ready_i) begin
          out_busy_d = 1'b0;
          if (!last_col) col_d = col_q + 1'b1;
          else col_d = '0;
        end else begin
          cmd_o.emit_read = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Valid holds for as long as the read data is held in the datapath.
  assign out_valid_o = stat_i.emit_valid;
  assign out_row_o = erow_q;
  assign out_col_o = 6'(col_q);
  assign out_lr_o = last_col;
  assign out_lb_o = last_col && lastb_q;
  assign out_lj_o = last_col && lastj_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StLoadB;
      rows_q <= 16'd1;
      depth_q <= 8'd1;
      cols_q <= 7'd1;
      batches_q <= 16'd1;
      bcnt_q <= '0;
      kpos_q <= '0;
      rowpos_q <= '0;
      batchpos_q <= '0;
      erow_q <= '0;
      col_q <= '0;
      kbase_q <= '0;
      lastb_q <= 1'b0;
      lastj_q <= 1'b0;
      out_busy_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegRowsM:      rows_q <= cfg_data_i;
        RegDepthK:     depth_q <= cfg_data_i[7:0];
        RegColsN:      cols_q <= cfg_data_i[6:0];
        RegBatchCount: batches_q <= cfg_data_i;
        default: ;
      endcase
      st_q <= StLoadB;
      bcnt_q <= '0;
      kpos_q <= '0;
      rowpos_q <= '0;
      batchpos_q <= '0;
      col_q <= '0;
      kbase_q <= '0;
      out_busy_q <= 1'b0;
    end else begin
      st_q <= st_d;
      bcnt_q <= bcnt_d;
      kpos_q <= kpos_d;
      rowpos_q <= rowpos_d;
      batchpos_q <= batchpos_d;
      erow_q <= erow_d;
      col_q <= col_d;
      kbase_q <= kbase_d;
      lastb_q <= lastb_d;
      lastj_q <= lastj_d;
      out_busy_q <= out_busy_d;
    end
  end

`ifndef SYNTH
  a_no_input_in_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StMac || st_q == StMacWait || st_q == StEmit) |-> !in_ready_o)
    else $error("input taken while busy");
  a_out_only_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> st_q == StEmit) else $error("result outside emit");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i && !cfg_we_i) |=> out_valid_o && $stable(col_q))
    else $error("result dropped under stall");
`endif

endmodule
`default_nettype wire

/* design/batched_float_matrix_multiply.sv */
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Payload
// in_if     in   value[31:0]
// out_if    out  result, row, col, last_of_row, last_of_batch, last_of_job
// cfg       in   cfg_we_i, cfg_idx_i[1:0], cfg_data_i[15:0]
//
// A B element is taken whenever one is offered while B loads. After an A
// element is taken, one shared multi-cycle FMA unit serves the N columns in
// turn, skipping the add when the addend is zero (first k) or an operand is special.
// A finished row is emitted one result at a time, held under output stalls.
// Reset is asynchronous, active low; the block then expects B of batch 0.
// Any configuration write restarts the job.
module batched_float_matrix_multiply
  import bfmm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  bfmm_stream_if.sink      in_if,
  bfmm_result_if.source    out_if
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     lr, lb, lj;

  bfmm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .out_ready_i(out_if.ready),
    .out_valid_o(out_if.valid),
    .out_row_o  (out_if.row),
    .out_col_o  (out_if.col),
    .out_lr_o   (lr),
    .out_lb_o   (lb),
    .out_lj_o   (lj)
  );

  bfmm_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .value_i(in_if.data),
    .stat_o (stat),
    .acc_o  (out_if.result)
  );

  assign out_if.last_of_row = lr;
  assign out_if.last_of_batch = lb;
  assign out_if.last_of_job = lj;

endmodule
`default_nettype wire
